@@ rtl/core/pcerr_pkg.sv @@
// Shared constants, tables and helpers for the Poisson count error bar core.
package pcerr_pkg;

    localparam int CNT_W          = 32;
    localparam int OUT_W          = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int TAB_MAX        = 20;
    localparam int IDX_W          = 5;
    localparam int TAB_N          = 2 ** IDX_W;
    localparam int H_W            = 10;
    localparam longint OUT_MAX    = (longint'(1) << OUT_W) - 1;

    typedef logic [TAB_N-1:0][OUT_W-1:0] t_tab;

    // Feldman-Cousins 68.27% limits as distances from the count, in hundredths
    localparam logic [H_W-1:0] LO_H [0:TAB_MAX] = '{
        10'd0,   10'd63,  10'd126, 10'd190, 10'd166, 10'd225, 10'd218,
        10'd275, 10'd270, 10'd267, 10'd322, 10'd319, 10'd317, 10'd373,
        10'd370, 10'd368, 10'd367, 10'd421, 10'd419, 10'd418, 10'd417
    };

    localparam logic [H_W-1:0] HI_H [0:TAB_MAX] = '{
        10'd129, 10'd175, 10'd225, 10'd230, 10'd278, 10'd281, 10'd328,
        10'd330, 10'd332, 10'd379, 10'd381, 10'd382, 10'd429, 10'd430,
        10'd432, 10'd432, 10'd480, 10'd481, 10'd482, 10'd482, 10'd530
    };

    // Hundredths to fixed point, round half up, saturated; unused slots are zero
    function automatic t_tab fix_tab(input logic is_hi, input int frac);
        t_tab   tab;
        longint h;
        longint v;
        tab = '0;
        for (int i = 0; i <= TAB_MAX; i++) begin
            h = is_hi ? longint'(HI_H[i]) : longint'(LO_H[i]);
            v = ((h << frac) + 64'sd50) / 64'sd100;
            if (v > OUT_MAX) begin
                v = OUT_MAX;
            end
            tab[i] = v[OUT_W-1:0];
        end
        return tab;
    endfunction

endpackage

@@ rtl/core/pcerr_isqrt_step.sv @@
// One restoring square-root iteration: two radicand bits in, one root bit out.
module pcerr_isqrt_step
    import pcerr_pkg::*;
#(
    parameter int QW = 16 + FRAC_BITS_DEF
) (
    input  logic [QW+1:0] i_rem,
    input  logic [QW-1:0] i_root,
    input  logic [1:0]    i_top2,
    output logic [QW+1:0] o_rem,
    output logic [QW-1:0] o_root
);

    logic [QW+1:0] w_rem_sh;
    logic [QW+1:0] w_trial;
    logic          w_take;

    // remainder never exceeds 2*root, so its top two bits are zero here
    assign w_rem_sh = {i_rem[QW-1:0], i_top2};
    assign w_trial  = {i_root, 2'b01};
    assign w_take   = (w_rem_sh >= w_trial);

    assign o_rem  = w_take ? (w_rem_sh - w_trial) : w_rem_sh;
    assign o_root = {i_root[QW-2:0], w_take};

endmodule

@@ rtl/core/poisson_count_error_bars_core.sv @@
// Throughput: one beat per cycle while the output is not stalled; the square root is one root bit per pipeline stage.
// Ready ripples back through empty stages, so bubbles are filled during an output stall.
// Reset (synchronous, active low) clears only the stage valid bits; no clearing pass.
// Counts 0..20 use a rounded table, larger counts a truncated square root, negatives flag.
module poisson_count_error_bars_core
    import pcerr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [CNT_W-1:0] i_event_count,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [OUT_W-1:0]        o_lower_error,
    output logic [OUT_W-1:0]        o_upper_error,
    output logic                    o_invalid_count
);

    localparam int QW = (CNT_W / 2) + FRAC_BITS;   // root bits
    localparam int RW = 2 * QW;                    // radicand bits
    localparam int NS = QW + 2;                    // input stage, QW root stages, output
    localparam int EW = (QW > OUT_W) ? QW : OUT_W + 1;
    localparam t_tab LO_TAB = fix_tab(1'b0, FRAC_BITS);
    localparam t_tab HI_TAB = fix_tab(1'b1, FRAC_BITS);

    logic [NS-1:0]   r_vld;
    logic [NS-1:0]   w_adv;

    logic [RW-1:0]   r_rad   [0:QW-1];
    logic [QW+1:0]   r_rem   [1:QW];
    logic [QW-1:0]   r_root  [1:QW];
    logic            r_neg   [0:QW];
    logic            r_small [0:QW];
    logic [OUT_W-1:0] r_lo   [1:QW];
    logic [OUT_W-1:0] r_hi   [1:QW];
    logic [IDX_W-1:0] r_idx;

    logic [OUT_W-1:0] r_out_lo;
    logic [OUT_W-1:0] r_out_hi;
    logic             r_out_neg;

    logic [QW+1:0]   w_rem_o  [0:QW-1];
    logic [QW-1:0]   w_root_o [0:QW-1];

    logic            w_small_in;
    logic [EW-1:0]   w_root_ext;
    logic [OUT_W-1:0] w_sqrt_sat;

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign w_small_in = !i_event_count[CNT_W-1] &&
                        (i_event_count <= (CNT_W)'(TAB_MAX));

    // input stage
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_neg[0]   <= i_event_count[CNT_W-1];
            r_small[0] <= w_small_in;
            r_idx      <= i_event_count[IDX_W-1:0];
            r_rad[0]   <= {1'b0, i_event_count[CNT_W-2:0], (2 * FRAC_BITS)'(0)};
        end
    end

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_root
            pcerr_isqrt_step #(
                .QW (QW)
            ) u_step (
                .i_rem  ((j == 0) ? (QW + 2)'(0) : r_rem[(j == 0) ? 1 : j]),
                .i_root ((j == 0) ? QW'(0)       : r_root[(j == 0) ? 1 : j]),
                .i_top2 (r_rad[j][RW-1:RW-2]),
                .o_rem  (w_rem_o[j]),
                .o_root (w_root_o[j])
            );

            always_ff @(posedge i_clk) begin
                if (w_adv[j+1]) begin
                    r_rem[j+1]   <= w_rem_o[j];
                    r_root[j+1]  <= w_root_o[j];
                    r_neg[j+1]   <= r_neg[j];
                    r_small[j+1] <= r_small[j];
                end
            end

            if (j == 0) begin : g_tab
                // table read rides along with the first root stage
                always_ff @(posedge i_clk) begin
                    if (w_adv[1]) begin
                        r_lo[1] <= r_small[0] ? LO_TAB[r_idx] : '0;
                        r_hi[1] <= r_small[0] ? HI_TAB[r_idx] : '0;
                    end
                end
            end else begin : g_carry
                always_ff @(posedge i_clk) begin
                    if (w_adv[j+1]) begin
                        r_lo[j+1] <= r_lo[j];
                        r_hi[j+1] <= r_hi[j];
                    end
                end
            end

            if (j < QW - 1) begin : g_rad
                always_ff @(posedge i_clk) begin
                    if (w_adv[j+1]) begin
                        r_rad[j+1] <= {r_rad[j][RW-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign w_root_ext = EW'(r_root[QW]);
    assign w_sqrt_sat = (w_root_ext > EW'(OUT_MAX)) ? OUT_W'(OUT_MAX)
                                                    : w_root_ext[OUT_W-1:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv[NS-1]) begin
            r_out_neg <= r_neg[QW];
            if (r_neg[QW]) begin
                r_out_lo <= '0;
                r_out_hi <= '0;
            end else if (r_small[QW]) begin
                r_out_lo <= r_lo[QW];
                r_out_hi <= r_hi[QW];
            end else begin
                r_out_lo <= w_sqrt_sat;
                r_out_hi <= w_sqrt_sat;
            end
        end
    end

    assign o_out_valid     = r_vld[NS-1];
    assign o_lower_error   = r_out_lo;
    assign o_upper_error   = r_out_hi;
    assign o_invalid_count = r_out_neg;

endmodule

@@ tb/sv/tb_poisson_count_error_bars_core.sv @@
// Testbench for poisson_count_error_bars_core: directed and random counts vs. a predictor.
`timescale 1ns / 100ps

module tb_poisson_count_error_bars_core;
    import pcerr_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int N_RANDOM     = 500;
    localparam int QUIET_TAIL   = 50;
    localparam int SETTLE_CYC   = FRAC + 40;
    localparam int INT_MAX_CNT  = 32'h7FFF_FFFF;
    localparam int INT_MIN_CNT  = 32'h8000_0000;

    // Feldman-Cousins 1-sigma errors, no background, in hundredths
    localparam int unsigned FC_LOW_CENTI [0:TAB_MAX] = '{
        0, 63, 126, 190, 166, 225, 218, 275, 270, 267, 322,
        319, 317, 373, 370, 368, 367, 421, 419, 418, 417
    };
    localparam int unsigned FC_HIGH_CENTI [0:TAB_MAX] = '{
        129, 175, 225, 230, 278, 281, 328, 330, 332, 379, 381,
        382, 429, 430, 432, 432, 480, 481, 482, 482, 530
    };

    typedef struct packed {
        logic signed [CNT_W-1:0] cnt;
        logic [OUT_W-1:0]        lower;
        logic [OUT_W-1:0]        upper;
        logic                    invalid;
    } err_bars_t;

    typedef struct packed {
        logic signed [CNT_W-1:0] cnt;
        logic                    drain_first;   // hold off until all results are back
        logic                    quiet;         // no gap after it; no new receiver stalls
    } count_beat_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [CNT_W-1:0] event_count = '0;
    logic                    o_out_valid;
    logic                    out_ready = 1'b0;
    logic [OUT_W-1:0]        o_lower_error;
    logic [OUT_W-1:0]        o_upper_error;
    logic                    o_invalid_count;

    count_beat_t pending_counts [$];
    err_bars_t   expected_bars [$];

    int  send_gap = 0;
    int  stall_left = 0;
    logic quiet_r = 1'b0;
    int  n_bad = 0;
    int  n_table = 0;
    int  n_root = 0;
    int  n_neg = 0;

    always #5 i_clk = ~i_clk;

    poisson_count_error_bars_core #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_event_count  (event_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_lower_error  (o_lower_error),
        .o_upper_error  (o_upper_error),
        .o_invalid_count(o_invalid_count)
    );

    function automatic logic [OUT_W-1:0] centi_to_fixed(input int unsigned centi);
        longint unsigned v;
        v = ((longint'(centi) << FRAC) + 50) / 100;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic err_bars_t calc_error_bars(input logic signed [CNT_W-1:0] cnt);
        err_bars_t       r;
        longint unsigned rad;
        longint unsigned root;
        longint unsigned bitv;
        r = '0;
        r.cnt = cnt;
        if (cnt < 0) begin
            r.invalid = 1'b1;
        end else if (cnt <= TAB_MAX) begin
            r.lower = centi_to_fixed(FC_LOW_CENTI[cnt]);
            r.upper = centi_to_fixed(FC_HIGH_CENTI[cnt]);
        end else begin
            // exact integer root of count * 2^(2*FRAC), truncated
            rad  = {32'b0, cnt} << (2 * FRAC);
            root = 0;
            bitv = 64'h1 << 62;
            while (bitv > rad) begin
                bitv = bitv >> 2;
            end
            while (bitv != 0) begin
                if (rad >= root + bitv) begin
                    rad  = rad - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            if (root > OUT_MAX) begin
                root = OUT_MAX;
            end
            r.lower = root[OUT_W-1:0];
            r.upper = root[OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [CNT_W-1:0] pick_count();
        int unsigned k;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom_range(0, TAB_MAX);
            3, 4:    return $urandom_range(TAB_MAX + 1, 2000);
            5, 6: begin
                // around perfect squares, where truncation is most fragile
                k = $urandom_range(5, 46340);
                return k * k + $urandom_range(0, 2) - 1;
            end
            7, 8:    return $urandom;
            default: return -$signed(CNT_W'($urandom_range(1, 50)));
        endcase
    endfunction

    // sender
    always @(posedge i_clk) begin
        count_beat_t b;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                expected_bars.push_back(calc_error_bars(event_count));
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_counts.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (pending_counts[0].drain_first && expected_bars.size() != 0) begin
                    in_valid <= 1'b0;
                end else begin
                    b = pending_counts.pop_front();
                    event_count <= b.cnt;
                    in_valid    <= 1'b1;
                    quiet_r     <= b.quiet;
                    if (!b.quiet && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet_r && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        err_bars_t e;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_bars.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("ERROR: unexpected beat lo=%0h hi=%0h inv=%0b",
                             o_lower_error, o_upper_error, o_invalid_count);
                end
            end else begin
                e = expected_bars.pop_front();
                if (e.invalid) n_neg++;
                else if (e.cnt <= TAB_MAX) n_table++;
                else n_root++;
                if (o_lower_error !== e.lower || o_upper_error !== e.upper ||
                    o_invalid_count !== e.invalid) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("ERROR: count %0d exp %0h/%0h/%0b got %0h/%0h/%0b",
                                 e.cnt, e.lower, e.upper, e.invalid,
                                 o_lower_error, o_upper_error, o_invalid_count);
                    end
                end
            end
        end
    end

    initial begin
        count_beat_t b;
        // directed: whole table, first root count, extremes, negatives
        for (int i = 0; i <= TAB_MAX; i++) begin
            pending_counts.push_back('{cnt: i, drain_first: 1'b0, quiet: 1'b0});
        end
        pending_counts.push_back('{cnt: TAB_MAX + 1, drain_first: 1'b0, quiet: 1'b0});
        pending_counts.push_back('{cnt: INT_MAX_CNT, drain_first: 1'b0, quiet: 1'b0});
        pending_counts.push_back('{cnt: -1, drain_first: 1'b0, quiet: 1'b0});
        pending_counts.push_back('{cnt: INT_MIN_CNT, drain_first: 1'b0, quiet: 1'b0});
        for (int i = 0; i < N_RANDOM; i++) begin
            b.cnt         = pick_count();
            b.drain_first = (i == 0 || i == 250);
            b.quiet       = (i >= 200 && i < 260) || (i >= N_RANDOM - QUIET_TAIL);
            pending_counts.push_back(b);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_counts.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_bars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d table counts, %0d square-root counts, %0d negative counts",
                 n_table, n_root, n_neg);
        $display("mismatches: %0d", n_bad);
        if (n_bad == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", expected_bars.size());
        $display("tb: failure");
        $finish;
    end

endmodule
